FILE: src/vpz_pkg.sv
// Shared types, constants and the microcode program of the viewport pan/zoom block.
package vpz_pkg;

	// Datapath widths
	localparam int EDGE_W = 64;               // stored bounds, signed Q8.56
	localparam int WORK_W = 80;               // intermediates never overflow this
	localparam int SPAN_W = 66;               // a span (edge difference) fits here
	localparam int PIX_W = 10;
	localparam int CMD_W = 3;
	localparam int STEP_W = 6;                // microcode address

	// Divider: one radix-256 digit per cycle
	localparam int RADIX_BITS = 8;
	localparam int DIGITS = WORK_W / RADIX_BITS;
	localparam int DIGIT_CNT_W = $clog2(DIGITS);

	localparam logic [EDGE_W-1:0] RESET_LOW = 64'hFE00_0000_0000_0000;   // -2.0
	localparam logic [EDGE_W-1:0] RESET_HIGH = 64'h0200_0000_0000_0000;  // +2.0

	// Command codes
	localparam logic [CMD_W-1:0] CMD_PAN_LEFT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PAN_RIGHT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PAN_UP = 3'd2;
	localparam logic [CMD_W-1:0] CMD_PAN_DOWN = 3'd3;
	localparam logic [CMD_W-1:0] CMD_ZOOM_IN = 3'd4;
	localparam logic [CMD_W-1:0] CMD_ZOOM_OUT = 3'd5;
	localparam logic [CMD_W-1:0] CMD_CURSOR_IN = 3'd6;
	localparam logic [CMD_W-1:0] CMD_CURSOR_OUT = 3'd7;

	// Program entry points
	localparam logic [STEP_W-1:0] ENTRY_PAN_X = 6'd0;
	localparam logic [STEP_W-1:0] ENTRY_PAN_Y = 6'd6;
	localparam logic [STEP_W-1:0] ENTRY_CENTRE = 6'd12;
	localparam logic [STEP_W-1:0] ENTRY_CURSOR = 6'd23;

	typedef enum logic [2:0] {
		REG_L, REG_R, REG_B, REG_T, REG_MX, REG_MY, REG_X, REG_Y
	} reg_sel_t;

	typedef enum logic [2:0] {
		ALU_NOP, ALU_ADD, ALU_SUB, ALU_NEG, ALU_MULPX, ALU_MULPY, ALU_MULN, ALU_DIV
	} alu_op_t;

	typedef enum logic [1:0] {
		DSEL_3, DSEL_W, DSEL_H, DSEL_D
	} div_sel_t;

	typedef enum logic [1:0] {
		COND_NONE, COND_ODD, COND_EVEN
	} cond_t;

	typedef struct packed {
		reg_sel_t              dst;
		reg_sel_t              src_a;
		reg_sel_t              src_b;
		alu_op_t               op;
		div_sel_t              dsel;
		cond_t                 cond;
		logic [STEP_W-1:0]     target;
		logic                  last;
	} uword_t;

	// Sequencer to datapath control
	typedef struct packed {
		logic      wr_en;
		reg_sel_t  dst;
		reg_sel_t  src_a;
		reg_sel_t  src_b;
		alu_op_t   op;
		div_sel_t  dsel;
		logic      odd;       // low bit of the command in flight
	} dp_ctl_t;

	typedef enum logic [1:0] {
		SQ_IDLE, SQ_RUN, SQ_EMIT
	} seq_state_t;

	typedef enum logic [1:0] {
		DV_IDLE, DV_RUN, DV_FIX, DV_DONE
	} div_state_t;

	function automatic uword_t u_alu(input reg_sel_t dst, input reg_sel_t a,
			input reg_sel_t b, input alu_op_t op, input logic last);
		uword_t w;
		w = '0;
		w.dst = dst;
		w.src_a = a;
		w.src_b = b;
		w.op = op;
		w.dsel = DSEL_3;
		w.cond = COND_NONE;
		w.last = last;
		return w;
	endfunction

	function automatic uword_t u_div(input reg_sel_t dst, input reg_sel_t a,
			input div_sel_t dsel);
		uword_t w;
		w = '0;
		w.dst = dst;
		w.src_a = a;
		w.src_b = a;
		w.op = ALU_DIV;
		w.dsel = dsel;
		w.cond = COND_NONE;
		return w;
	endfunction

	function automatic uword_t u_jmp(input cond_t c, input logic [STEP_W-1:0] target);
		uword_t w;
		w = '0;
		w.op = ALU_NOP;
		w.dsel = DSEL_3;
		w.cond = c;
		w.target = target;
		return w;
	endfunction

	// Microcode ROM
	function automatic uword_t ucode(input logic [STEP_W-1:0] step);
		uword_t w;
		case (step)
			// pan left / right
			6'd0: w = u_alu(REG_X, REG_R, REG_L, ALU_SUB, 1'b0);
			6'd1: w = u_jmp(COND_ODD, 6'd3);
			6'd2: w = u_alu(REG_X, REG_X, REG_X, ALU_NEG, 1'b0);
			6'd3: w = u_div(REG_X, REG_X, DSEL_3);
			6'd4: w = u_alu(REG_L, REG_L, REG_X, ALU_ADD, 1'b0);
			6'd5: w = u_alu(REG_R, REG_R, REG_X, ALU_ADD, 1'b1);
			// pan up / down
			6'd6: w = u_alu(REG_Y, REG_T, REG_B, ALU_SUB, 1'b0);
			6'd7: w = u_jmp(COND_EVEN, 6'd9);
			6'd8: w = u_alu(REG_Y, REG_Y, REG_Y, ALU_NEG, 1'b0);
			6'd9: w = u_div(REG_Y, REG_Y, DSEL_3);
			6'd10: w = u_alu(REG_B, REG_B, REG_Y, ALU_ADD, 1'b0);
			6'd11: w = u_alu(REG_T, REG_T, REG_Y, ALU_ADD, 1'b1);
			// centre zoom
			6'd12: w = u_alu(REG_X, REG_R, REG_L, ALU_SUB, 1'b0);
			6'd13: w = u_div(REG_X, REG_X, DSEL_3);
			6'd14: w = u_alu(REG_Y, REG_T, REG_B, ALU_SUB, 1'b0);
			6'd15: w = u_div(REG_Y, REG_Y, DSEL_3);
			6'd16: w = u_jmp(COND_EVEN, 6'd19);
			6'd17: w = u_alu(REG_X, REG_X, REG_X, ALU_NEG, 1'b0);
			6'd18: w = u_alu(REG_Y, REG_Y, REG_Y, ALU_NEG, 1'b0);
			6'd19: w = u_alu(REG_L, REG_L, REG_X, ALU_ADD, 1'b0);
			6'd20: w = u_alu(REG_R, REG_R, REG_X, ALU_SUB, 1'b0);
			6'd21: w = u_alu(REG_B, REG_B, REG_Y, ALU_ADD, 1'b0);
			6'd22: w = u_alu(REG_T, REG_T, REG_Y, ALU_SUB, 1'b1);
			// cursor zoom: find the anchor point
			6'd23: w = u_alu(REG_X, REG_R, REG_L, ALU_SUB, 1'b0);
			6'd24: w = u_alu(REG_X, REG_X, REG_X, ALU_MULPX, 1'b0);
			6'd25: w = u_div(REG_X, REG_X, DSEL_W);
			6'd26: w = u_alu(REG_MX, REG_L, REG_X, ALU_ADD, 1'b0);
			6'd27: w = u_alu(REG_Y, REG_T, REG_B, ALU_SUB, 1'b0);
			6'd28: w = u_alu(REG_Y, REG_Y, REG_Y, ALU_MULPY, 1'b0);
			6'd29: w = u_div(REG_Y, REG_Y, DSEL_H);
			6'd30: w = u_alu(REG_MY, REG_T, REG_Y, ALU_SUB, 1'b0);
			// cursor zoom: rescale each edge about the anchor
			6'd31: w = u_alu(REG_X, REG_MX, REG_L, ALU_SUB, 1'b0);
			6'd32: w = u_alu(REG_X, REG_X, REG_X, ALU_MULN, 1'b0);
			6'd33: w = u_div(REG_X, REG_X, DSEL_D);
			6'd34: w = u_alu(REG_L, REG_MX, REG_X, ALU_SUB, 1'b0);
			6'd35: w = u_alu(REG_X, REG_R, REG_MX, ALU_SUB, 1'b0);
			6'd36: w = u_alu(REG_X, REG_X, REG_X, ALU_MULN, 1'b0);
			6'd37: w = u_div(REG_X, REG_X, DSEL_D);
			6'd38: w = u_alu(REG_R, REG_MX, REG_X, ALU_ADD, 1'b0);
			6'd39: w = u_alu(REG_Y, REG_MY, REG_B, ALU_SUB, 1'b0);
			6'd40: w = u_alu(REG_Y, REG_Y, REG_Y, ALU_MULN, 1'b0);
			6'd41: w = u_div(REG_Y, REG_Y, DSEL_D);
			6'd42: w = u_alu(REG_B, REG_MY, REG_Y, ALU_SUB, 1'b0);
			6'd43: w = u_alu(REG_Y, REG_T, REG_MY, ALU_SUB, 1'b0);
			6'd44: w = u_alu(REG_Y, REG_Y, REG_Y, ALU_MULN, 1'b0);
			6'd45: w = u_div(REG_Y, REG_Y, DSEL_D);
			6'd46: w = u_alu(REG_T, REG_MY, REG_Y, ALU_ADD, 1'b1);
			default: w = u_alu(REG_X, REG_X, REG_X, ALU_NOP, 1'b1);
		endcase
		return w;
	endfunction

	// Dispatch: command to program entry
	function automatic logic [STEP_W-1:0] entry(input logic [CMD_W-1:0] cmd);
		logic [STEP_W-1:0] e;
		case (cmd)
			CMD_PAN_LEFT, CMD_PAN_RIGHT: e = ENTRY_PAN_X;
			CMD_PAN_UP, CMD_PAN_DOWN: e = ENTRY_PAN_Y;
			CMD_ZOOM_IN, CMD_ZOOM_OUT: e = ENTRY_CENTRE;
			CMD_CURSOR_IN, CMD_CURSOR_OUT: e = ENTRY_CURSOR;
			default: e = ENTRY_PAN_X;
		endcase
		return e;
	endfunction

endpackage

FILE: src/viewport_pan_zoom.sv
// Top level of the viewport pan/zoom block: microcode sequencer, datapath and shared divider.
// Each divide step holds the sequencer through the divider's start, ten radix-256 digits and fixup.
// One command at a time; a new command is taken the cycle after
// its predecessor's result is loaded into the output register, which may still wait on out_stall.
// Reset: view bounds return to [-2.0, 2.0] on both axes, output register empty.
module viewport_pan_zoom #(
	parameter int IMAGE_WIDTH = 1024,
	parameter int IMAGE_HEIGHT = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [vpz_pkg::CMD_W-1:0]         cmd,
	input  logic [vpz_pkg::PIX_W-1:0]         px,
	input  logic [vpz_pkg::PIX_W-1:0]         py,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [vpz_pkg::EDGE_W-1:0] left_edge,
	output logic signed [vpz_pkg::EDGE_W-1:0] right_edge,
	output logic signed [vpz_pkg::EDGE_W-1:0] bottom_edge,
	output logic signed [vpz_pkg::EDGE_W-1:0] top_edge
);

	// Divisors are 3, 2 or the image dimensions; size the divider for the largest.
	localparam int MAX_DIM = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
	localparam int DIV_W = $clog2(MAX_DIM + 1);

	logic                       accept;
	logic                       busy;
	logic                       emit;
	logic                       out_free;
	logic                       div_start;
	logic                       div_done;
	vpz_pkg::dp_ctl_t           ctl;
	logic [vpz_pkg::WORK_W-1:0] dividend;
	logic [vpz_pkg::WORK_W-1:0] div_quot;
	logic [DIV_W-1:0]           divisor;
	logic [vpz_pkg::EDGE_W-1:0] view_left, view_right, view_bottom, view_top;

	logic                       out_valid_q;
	logic [vpz_pkg::EDGE_W-1:0] left_q, right_q, bottom_q, top_q;

	// One command in the sequencer at a time; stall is high while it runs.
	assign in_stall = busy;
	assign accept = in_valid && !busy;

	// Output register can take a new result when empty or being drained this cycle.
	assign out_free = !out_valid_q || !out_stall;

	// Sequencer walks the microcode program picked by the command.
	vpz_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.cmd       (cmd),
		.div_done  (div_done),
		.out_free  (out_free),
		.busy      (busy),
		.emit      (emit),
		.div_start (div_start),
		.ctl       (ctl)
	);

	// Bounds, scratch registers, add/sub, pixel multiply, saturating write-back.
	vpz_datapath #(
		.IMAGE_WIDTH  (IMAGE_WIDTH),
		.IMAGE_HEIGHT (IMAGE_HEIGHT),
		.DIV_W        (DIV_W)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (accept),
		.px          (px),
		.py          (py),
		.ctl         (ctl),
		.div_quot    (div_quot),
		.dividend    (dividend),
		.divisor     (divisor),
		.view_left   (view_left),
		.view_right  (view_right),
		.view_bottom (view_bottom),
		.view_top    (view_top)
	);

	// Shared floor divider for thirds, halves and pixel-to-plane scaling.
	vpz_div #(
		.DIV_W (DIV_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Result register: snapshot of the bounds after the last program step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			left_q <= view_left;
			right_q <= view_right;
			bottom_q <= view_bottom;
			top_q <= view_top;
		end
	end

	assign out_valid = out_valid_q;
	assign left_edge = left_q;
	assign right_edge = right_q;
	assign bottom_edge = bottom_q;
	assign top_edge = top_q;

endmodule

FILE: src/vpz_div.sv
// Signed floor divider by a small unsigned divisor, one radix-256 digit per cycle.
module vpz_div #(
	parameter int DIV_W = 13
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [vpz_pkg::WORK_W-1:0]    dividend,
	input  logic [DIV_W-1:0]              divisor,
	output logic                          done,
	output logic [vpz_pkg::WORK_W-1:0]    quotient
);

	vpz_pkg::div_state_t state_q, state_d;
	logic [vpz_pkg::DIGIT_CNT_W-1:0] cnt_q;
	logic                            neg_q;
	logic [DIV_W-1:0]                d_q;
	logic [DIV_W-1:0]                rem_q;
	logic [vpz_pkg::WORK_W-1:0]      acc_q;    // magnitude, then quotient

	logic [DIV_W:0]                  cur;
	logic [DIV_W-1:0]                rem_n;
	logic [vpz_pkg::RADIX_BITS-1:0]  qbits;
	logic [vpz_pkg::WORK_W-1:0]      mag;
	logic                            last_digit;

	assign mag = dividend[vpz_pkg::WORK_W-1] ? -dividend : dividend;
	assign last_digit = (cnt_q == vpz_pkg::DIGIT_CNT_W'(vpz_pkg::DIGITS - 1));

	// one digit of restoring long division
	always_comb begin
		rem_n = rem_q;
		qbits = '0;
		cur = '0;
		for (int i = 0; i < vpz_pkg::RADIX_BITS; i++) begin
			cur = {rem_n, acc_q[vpz_pkg::WORK_W-1-i]};
			if (cur >= {1'b0, d_q}) begin
				cur = cur - {1'b0, d_q};
				qbits[vpz_pkg::RADIX_BITS-1-i] = 1'b1;
			end
			rem_n = cur[DIV_W-1:0];
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			vpz_pkg::DV_IDLE: if (start) state_d = vpz_pkg::DV_RUN;
			vpz_pkg::DV_RUN: if (last_digit) state_d = vpz_pkg::DV_FIX;
			vpz_pkg::DV_FIX: state_d = vpz_pkg::DV_DONE;
			vpz_pkg::DV_DONE: state_d = vpz_pkg::DV_IDLE;
			default: state_d = vpz_pkg::DV_IDLE;
		endcase
	end

	always_comb begin
		done = 1'b0;
		case (state_q)
			vpz_pkg::DV_DONE: done = 1'b1;
			default: done = 1'b0;
		endcase
	end

	assign quotient = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vpz_pkg::DV_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == vpz_pkg::DV_IDLE)
				cnt_q <= '0;
			else if (state_q == vpz_pkg::DV_RUN)
				cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			vpz_pkg::DV_IDLE: begin
				if (start) begin
					neg_q <= dividend[vpz_pkg::WORK_W-1];
					d_q <= divisor;
					rem_q <= '0;
					acc_q <= mag;
				end
			end
			vpz_pkg::DV_RUN: begin
				rem_q <= rem_n;
				acc_q <= {acc_q[vpz_pkg::WORK_W-vpz_pkg::RADIX_BITS-1:0], qbits};
			end
			vpz_pkg::DV_FIX: begin
				// floor for negatives: -(q + (rem != 0)) == ~q + (rem == 0)
				if (neg_q)
					acc_q <= ~acc_q + vpz_pkg::WORK_W'(rem_q == '0);
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: src/vpz_seq.sv
// Microcode sequencer: step counter, dispatch, conditional jumps, divider wait and output wait.
module vpz_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [vpz_pkg::CMD_W-1:0]     cmd,
	input  logic                          div_done,
	input  logic                          out_free,
	output logic                          busy,
	output logic                          emit,
	output logic                          div_start,
	output vpz_pkg::dp_ctl_t              ctl
);

	vpz_pkg::seq_state_t state_q, state_d;
	logic [vpz_pkg::STEP_W-1:0] pc_q;
	logic                       odd_q;
	logic                       div_wait_q;

	vpz_pkg::uword_t uw;
	logic            cond_hit;
	logic            wr_en;
	logic            step_done;

	assign uw = vpz_pkg::ucode(pc_q);
	assign cond_hit = ((uw.cond == vpz_pkg::COND_ODD) && odd_q) ||
		((uw.cond == vpz_pkg::COND_EVEN) && !odd_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			vpz_pkg::SQ_IDLE: if (accept) state_d = vpz_pkg::SQ_RUN;
			vpz_pkg::SQ_RUN: if (step_done && uw.last) state_d = vpz_pkg::SQ_EMIT;
			vpz_pkg::SQ_EMIT: if (out_free) state_d = vpz_pkg::SQ_IDLE;
			default: state_d = vpz_pkg::SQ_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		wr_en = 1'b0;
		step_done = 1'b0;
		div_start = 1'b0;
		emit = 1'b0;
		busy = 1'b1;
		case (state_q)
			vpz_pkg::SQ_IDLE: busy = 1'b0;
			vpz_pkg::SQ_RUN: begin
				case (uw.op)
					vpz_pkg::ALU_NOP: step_done = 1'b1;
					vpz_pkg::ALU_DIV: begin
						if (!div_wait_q) begin
							div_start = 1'b1;
						end else if (div_done) begin
							wr_en = 1'b1;
							step_done = 1'b1;
						end
					end
					default: begin
						wr_en = 1'b1;
						step_done = 1'b1;
					end
				endcase
			end
			vpz_pkg::SQ_EMIT: emit = out_free;
			default: busy = 1'b1;
		endcase
	end

	assign ctl.wr_en = wr_en;
	assign ctl.dst = uw.dst;
	assign ctl.src_a = uw.src_a;
	assign ctl.src_b = uw.src_b;
	assign ctl.op = uw.op;
	assign ctl.dsel = uw.dsel;
	assign ctl.odd = odd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vpz_pkg::SQ_IDLE;
			pc_q <= '0;
			odd_q <= 1'b0;
			div_wait_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				pc_q <= vpz_pkg::entry(cmd);
				odd_q <= cmd[0];
			end else if (step_done) begin
				if ((uw.op == vpz_pkg::ALU_NOP) && cond_hit)
					pc_q <= uw.target;
				else
					pc_q <= pc_q + 1'b1;
			end
			if (div_start)
				div_wait_q <= 1'b1;
			else if (step_done)
				div_wait_q <= 1'b0;
		end
	end

endmodule

FILE: src/vpz_datapath.sv
// Datapath: view bounds, scratch registers, adder, pixel multiplier and saturation.
module vpz_datapath #(
	parameter int IMAGE_WIDTH = 1024,
	parameter int IMAGE_HEIGHT = 1024,
	parameter int DIV_W = 13
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic [vpz_pkg::PIX_W-1:0]     px,
	input  logic [vpz_pkg::PIX_W-1:0]     py,
	input  vpz_pkg::dp_ctl_t              ctl,
	input  logic [vpz_pkg::WORK_W-1:0]    div_quot,
	output logic [vpz_pkg::WORK_W-1:0]    dividend,
	output logic [DIV_W-1:0]              divisor,
	output logic [vpz_pkg::EDGE_W-1:0]    view_left,
	output logic [vpz_pkg::EDGE_W-1:0]    view_right,
	output logic [vpz_pkg::EDGE_W-1:0]    view_bottom,
	output logic [vpz_pkg::EDGE_W-1:0]    view_top
);

	localparam int EXT_W = vpz_pkg::WORK_W - vpz_pkg::EDGE_W;
	localparam int PROD_W = vpz_pkg::SPAN_W + vpz_pkg::PIX_W + 1;

	logic [vpz_pkg::EDGE_W-1:0] l_q, r_q, b_q, t_q;
	logic [vpz_pkg::WORK_W-1:0] mx_q, my_q, x_q, y_q;
	logic [vpz_pkg::PIX_W-1:0]  px_q, py_q;

	logic [vpz_pkg::WORK_W-1:0] a_op, b_op, res;
	logic [vpz_pkg::PIX_W-1:0]  mul_pix;
	logic signed [PROD_W-1:0]   prod;
	logic [vpz_pkg::EDGE_W-1:0] res_sat;

	function automatic logic [vpz_pkg::EDGE_W-1:0] sat_edge(
			input logic [vpz_pkg::WORK_W-1:0] v);
		logic [EXT_W:0] hi;
		hi = v[vpz_pkg::WORK_W-1:vpz_pkg::EDGE_W-1];
		if ((hi == '0) || (hi == '1))
			return v[vpz_pkg::EDGE_W-1:0];
		else if (v[vpz_pkg::WORK_W-1])
			return {1'b1, {(vpz_pkg::EDGE_W-1){1'b0}}};
		else
			return {1'b0, {(vpz_pkg::EDGE_W-1){1'b1}}};
	endfunction

	function automatic logic [vpz_pkg::WORK_W-1:0] sext(input logic [vpz_pkg::EDGE_W-1:0] v);
		return {{EXT_W{v[vpz_pkg::EDGE_W-1]}}, v};
	endfunction

	always_comb begin
		case (ctl.src_a)
			vpz_pkg::REG_L: a_op = sext(l_q);
			vpz_pkg::REG_R: a_op = sext(r_q);
			vpz_pkg::REG_B: a_op = sext(b_q);
			vpz_pkg::REG_T: a_op = sext(t_q);
			vpz_pkg::REG_MX: a_op = mx_q;
			vpz_pkg::REG_MY: a_op = my_q;
			vpz_pkg::REG_X: a_op = x_q;
			vpz_pkg::REG_Y: a_op = y_q;
			default: a_op = x_q;
		endcase
	end

	always_comb begin
		case (ctl.src_b)
			vpz_pkg::REG_L: b_op = sext(l_q);
			vpz_pkg::REG_R: b_op = sext(r_q);
			vpz_pkg::REG_B: b_op = sext(b_q);
			vpz_pkg::REG_T: b_op = sext(t_q);
			vpz_pkg::REG_MX: b_op = mx_q;
			vpz_pkg::REG_MY: b_op = my_q;
			vpz_pkg::REG_X: b_op = x_q;
			vpz_pkg::REG_Y: b_op = y_q;
			default: b_op = x_q;
		endcase
	end

	// span times cursor pixel; operand A holds a span here
	assign mul_pix = (ctl.op == vpz_pkg::ALU_MULPY) ? py_q : px_q;
	assign prod = $signed(a_op[vpz_pkg::SPAN_W-1:0]) * $signed({1'b0, mul_pix});

	always_comb begin
		case (ctl.op)
			vpz_pkg::ALU_ADD: res = a_op + b_op;
			vpz_pkg::ALU_SUB: res = a_op - b_op;
			vpz_pkg::ALU_NEG: res = -a_op;
			vpz_pkg::ALU_MULPX,
			vpz_pkg::ALU_MULPY:
				res = {{(vpz_pkg::WORK_W-PROD_W){prod[PROD_W-1]}}, prod};
			vpz_pkg::ALU_MULN: res = (a_op << 1) + (ctl.odd ? a_op : '0);
			vpz_pkg::ALU_DIV: res = div_quot;
			default: res = a_op;
		endcase
	end

	assign res_sat = sat_edge(res);

	always_comb begin
		case (ctl.dsel)
			vpz_pkg::DSEL_3: divisor = DIV_W'(3);
			vpz_pkg::DSEL_W: divisor = DIV_W'(IMAGE_WIDTH);
			vpz_pkg::DSEL_H: divisor = DIV_W'(IMAGE_HEIGHT);
			vpz_pkg::DSEL_D: divisor = ctl.odd ? DIV_W'(2) : DIV_W'(3);
			default: divisor = DIV_W'(3);
		endcase
	end

	assign dividend = a_op;

	// view bounds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l_q <= vpz_pkg::RESET_LOW;
			r_q <= vpz_pkg::RESET_HIGH;
			b_q <= vpz_pkg::RESET_LOW;
			t_q <= vpz_pkg::RESET_HIGH;
		end else if (ctl.wr_en) begin
			case (ctl.dst)
				vpz_pkg::REG_L: l_q <= res_sat;
				vpz_pkg::REG_R: r_q <= res_sat;
				vpz_pkg::REG_B: b_q <= res_sat;
				vpz_pkg::REG_T: t_q <= res_sat;
				default: begin
				end
			endcase
		end
	end

	// scratch and latched cursor
	always_ff @(posedge clk) begin
		if (load) begin
			px_q <= px;
			py_q <= py;
		end
		if (ctl.wr_en) begin
			case (ctl.dst)
				vpz_pkg::REG_MX: mx_q <= res;
				vpz_pkg::REG_MY: my_q <= res;
				vpz_pkg::REG_X: x_q <= res;
				vpz_pkg::REG_Y: y_q <= res;
				default: begin
				end
			endcase
		end
	end

	assign view_left = l_q;
	assign view_right = r_q;
	assign view_bottom = b_q;
	assign view_top = t_q;

endmodule

FILE: src/vpz_checker.sv
// Port-level checks on the viewport pan/zoom block, bound to its top level.
module vpz_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic signed [vpz_pkg::EDGE_W-1:0] left_edge,
	input  logic signed [vpz_pkg::EDGE_W-1:0] right_edge,
	input  logic signed [vpz_pkg::EDGE_W-1:0] bottom_edge,
	input  logic signed [vpz_pkg::EDGE_W-1:0] top_edge
);

	// a taken command keeps the block busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("command taken while no longer busy");

	// a new result only appears at the end of a busy stretch
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a command in work");

	// after a result is produced the block is ready for the next command
	a_ready_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("still busy after result load");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(left_edge) && $stable(right_edge) &&
			$stable(bottom_edge) && $stable(top_edge)))
		else $error("result changed while stalled");

endmodule

bind viewport_pan_zoom vpz_checker u_vpz_checker (.*);

FILE: sim/tb_viewport_pan_zoom.sv
// Testbench for viewport_pan_zoom: directed and random commands checked against a predictor.
`timescale 1ns / 100ps

module tb_viewport_pan_zoom;

	localparam int CLK_PERIOD = 10;
	localparam int RESET_CYCLES = 8;
	localparam int IMG_W = 1024;
	localparam int IMG_H = 1024;
	localparam int HOLD_CYCLES = 600;      // long output hold-off, fills the block
	localparam int SETTLE_CYCLES = 120;    // a little over the slowest command (cursor zoom)
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASE_ITEMS = 325;

	// Predictor arithmetic runs on wide signed integers so nothing overflows
	// before the final clamp to the edge format.
	typedef logic signed [127:0] wide_t;
	localparam wide_t EDGE_MAX = {65'd0, {63{1'b1}}};
	localparam wide_t EDGE_MIN = -EDGE_MAX - 1;
	localparam wide_t PIX_SCALE_X = IMG_W;
	localparam wide_t PIX_SCALE_Y = IMG_H;
	localparam wide_t THIRD = 3;

	typedef struct {
		logic [vpz_pkg::CMD_W-1:0] cmd;
		logic [vpz_pkg::PIX_W-1:0] px;
		logic [vpz_pkg::PIX_W-1:0] py;
	} view_cmd_t;

	typedef struct {
		logic signed [vpz_pkg::EDGE_W-1:0] left;
		logic signed [vpz_pkg::EDGE_W-1:0] right;
		logic signed [vpz_pkg::EDGE_W-1:0] bottom;
		logic signed [vpz_pkg::EDGE_W-1:0] top;
	} bounds_t;

	// DUT connections; every input has a known value from time zero
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [vpz_pkg::CMD_W-1:0] cmd = '0;
	logic [vpz_pkg::PIX_W-1:0] px = '0;
	logic [vpz_pkg::PIX_W-1:0] py = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [vpz_pkg::EDGE_W-1:0] left_edge;
	logic signed [vpz_pkg::EDGE_W-1:0] right_edge;
	logic signed [vpz_pkg::EDGE_W-1:0] bottom_edge;
	logic signed [vpz_pkg::EDGE_W-1:0] top_edge;

	// Predicted view window, tracks the block's state
	logic signed [vpz_pkg::EDGE_W-1:0] view_l;
	logic signed [vpz_pkg::EDGE_W-1:0] view_r;
	logic signed [vpz_pkg::EDGE_W-1:0] view_b;
	logic signed [vpz_pkg::EDGE_W-1:0] view_t;

	view_cmd_t pending_cmds[$];       // commands not yet taken by the block
	bounds_t expected_bounds[$];      // window predicted for each taken command

	// Traffic shaping, changed by the stimulus process on the falling edge
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_reqs = 0;
	int hold_seen = 0;
	int hold_left = 0;

	int fail_count = 0;
	int cycle_count = 0;

	viewport_pan_zoom #(
		.IMAGE_WIDTH(IMG_W),
		.IMAGE_HEIGHT(IMG_H)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.px(px),
		.py(py),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.left_edge(left_edge),
		.right_edge(right_edge),
		.bottom_edge(bottom_edge),
		.top_edge(top_edge)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Division rounding toward minus infinity; divisor is always positive.
	function automatic wide_t floor_div(input wide_t num, input wide_t den);
		wide_t q;
		q = num / den;
		if (num < 0 && (num % den) != 0)
			q = q - 1;
		return q;
	endfunction

	// Clamp to the signed 64-bit edge range; each edge clamps on its own.
	function automatic logic signed [vpz_pkg::EDGE_W-1:0] clamp_edge(input wide_t v);
		if (v > EDGE_MAX)
			return EDGE_MAX[vpz_pkg::EDGE_W-1:0];
		if (v < EDGE_MIN)
			return EDGE_MIN[vpz_pkg::EDGE_W-1:0];
		return v[vpz_pkg::EDGE_W-1:0];
	endfunction

	// Apply one command to the predicted window and return the new bounds.
	// Spans may go negative after clamping; the same formulas hold.
	function automatic bounds_t next_window(input logic [vpz_pkg::CMD_W-1:0] c,
			input logic [vpz_pkg::PIX_W-1:0] col, input logic [vpz_pkg::PIX_W-1:0] row);
		wide_t l, r, b, t, w, h, nl, nr, nb, nt, dx, dy, mx, my, num, den;
		bounds_t res;
		l = view_l;
		r = view_r;
		b = view_b;
		t = view_t;
		w = r - l;
		h = t - b;
		nl = l;
		nr = r;
		nb = b;
		nt = t;
		case (c)
			vpz_pkg::CMD_PAN_LEFT, vpz_pkg::CMD_PAN_RIGHT: begin
				dx = floor_div((c == vpz_pkg::CMD_PAN_LEFT) ? -w : w, THIRD);
				nl = l + dx;
				nr = r + dx;
			end
			vpz_pkg::CMD_PAN_UP, vpz_pkg::CMD_PAN_DOWN: begin
				dy = floor_div((c == vpz_pkg::CMD_PAN_DOWN) ? -h : h, THIRD);
				nb = b + dy;
				nt = t + dy;
			end
			vpz_pkg::CMD_ZOOM_IN, vpz_pkg::CMD_ZOOM_OUT: begin
				dx = floor_div(w, THIRD);
				dy = floor_div(h, THIRD);
				if (c == vpz_pkg::CMD_ZOOM_OUT) begin
					dx = -dx;
					dy = -dy;
				end
				nl = l + dx;
				nr = r - dx;
				nb = b + dy;
				nt = t - dy;
			end
			default: begin
				// cursor zoom: anchor at the pixel, row 0 on the top edge,
				// then scale each edge's distance by 2/3 (in) or 3/2 (out)
				num = (c == vpz_pkg::CMD_CURSOR_IN) ? 2 : 3;
				den = (c == vpz_pkg::CMD_CURSOR_IN) ? 3 : 2;
				mx = l + floor_div(w * wide_t'(col), PIX_SCALE_X);
				my = t - floor_div(h * wide_t'(row), PIX_SCALE_Y);
				nl = mx - floor_div((mx - l) * num, den);
				nr = mx + floor_div((r - mx) * num, den);
				nb = my - floor_div((my - b) * num, den);
				nt = my + floor_div((t - my) * num, den);
			end
		endcase
		view_l = clamp_edge(nl);
		view_r = clamp_edge(nr);
		view_b = clamp_edge(nb);
		view_t = clamp_edge(nt);
		res.left = view_l;
		res.right = view_r;
		res.bottom = view_b;
		res.top = view_t;
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Driver: presents the head of pending_cmds, holds it while stalled
	// ------------------------------------------------------------------
	always @(posedge clk) begin : drive_cmds
		logic taken;
		logic offer;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			taken = in_valid && !in_stall;
			if (taken) begin
				// payload regs still hold the accepted transaction here
				expected_bounds.push_back(next_window(cmd, px, py));
				void'(pending_cmds.pop_front());
			end
			if (in_valid && !taken)
				offer = 1'b1;
			else
				offer = (pending_cmds.size() > 0) &&
					($urandom_range(99) >= send_idle_pct);
			in_valid <= offer;
			if (offer) begin
				cmd <= pending_cmds[0].cmd;
				px <= pending_cmds[0].px;
				py <= pending_cmds[0].py;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks each result transaction, drives out_stall
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		bounds_t want;
		logic stall;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_bounds.size() == 0) begin
				$error("result with no command outstanding: %h %h %h %h",
					left_edge, right_edge, bottom_edge, top_edge);
				fail_count++;
			end else begin
				want = expected_bounds.pop_front();
				if (left_edge !== want.left) begin
					$error("left_edge: expected %h, got %h", want.left, left_edge);
					fail_count++;
				end
				if (right_edge !== want.right) begin
					$error("right_edge: expected %h, got %h", want.right, right_edge);
					fail_count++;
				end
				if (bottom_edge !== want.bottom) begin
					$error("bottom_edge: expected %h, got %h", want.bottom, bottom_edge);
					fail_count++;
				end
				if (top_edge !== want.top) begin
					$error("top_edge: expected %h, got %h", want.top, top_edge);
					fail_count++;
				end
			end
		end
		// a new hold request starts a long stall stretch, counted here
		if (hold_seen != hold_reqs) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			stall = 1'b1;
		end else begin
			stall = ($urandom_range(99) < recv_stall_pct);
		end
		out_stall <= stall;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_viewport_pan_zoom failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	task automatic queue_cmd(input logic [vpz_pkg::CMD_W-1:0] c, input int col,
			input int row);
		view_cmd_t item;
		item.cmd = c;
		item.px = col[vpz_pkg::PIX_W-1:0];
		item.py = row[vpz_pkg::PIX_W-1:0];
		pending_cmds.push_back(item);
	endtask

	// Cursor position, leaning on the image corners now and then
	function automatic int pick_pixel();
		case ($urandom_range(9))
			0: return 0;
			1: return (1 << vpz_pkg::PIX_W) - 1;
			default: return $urandom_range((1 << vpz_pkg::PIX_W) - 1);
		endcase
	endfunction

	// Random command mix. Bursts of one command push the window into
	// saturation (repeated zoom out / pans) or deep magnification.
	task automatic queue_random_cmds(input int count);
		int queued;
		int burst;
		logic [vpz_pkg::CMD_W-1:0] c;
		queued = 0;
		while (queued < count) begin
			c = vpz_pkg::CMD_W'($urandom_range(7));
			burst = ($urandom_range(99) < 15) ? $urandom_range(12, 4) : 1;
			repeat (burst) begin
				queue_cmd(c, pick_pixel(), pick_pixel());
				queued++;
			end
		end
	endtask

	// Sender pause: nothing new goes out until every result is back
	task automatic wait_drained();
		while (pending_cmds.size() != 0 || expected_bounds.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct, input int count,
			input logic with_hold);
		@(negedge clk);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		if (with_hold)
			hold_reqs++;
		queue_random_cmds(count);
		wait_drained();
	endtask

	initial begin
		view_l = vpz_pkg::RESET_LOW;
		view_r = vpz_pkg::RESET_HIGH;
		view_b = vpz_pkg::RESET_LOW;
		view_t = vpz_pkg::RESET_HIGH;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: every command from the reset window, cursor at the
		// image corners and centre, then zoom out until the edges clamp
		// and work on the saturated window.
		queue_cmd(vpz_pkg::CMD_PAN_LEFT, 0, 0);
		queue_cmd(vpz_pkg::CMD_PAN_RIGHT, 0, 0);
		queue_cmd(vpz_pkg::CMD_PAN_UP, 0, 0);
		queue_cmd(vpz_pkg::CMD_PAN_DOWN, 0, 0);
		queue_cmd(vpz_pkg::CMD_ZOOM_IN, 0, 0);
		queue_cmd(vpz_pkg::CMD_ZOOM_OUT, 0, 0);
		queue_cmd(vpz_pkg::CMD_CURSOR_IN, 0, 0);
		queue_cmd(vpz_pkg::CMD_CURSOR_OUT, 1023, 1023);
		queue_cmd(vpz_pkg::CMD_CURSOR_IN, 512, 512);
		queue_cmd(vpz_pkg::CMD_CURSOR_OUT, 0, 1023);
		queue_cmd(vpz_pkg::CMD_CURSOR_IN, 1023, 0);
		repeat (9) queue_cmd(vpz_pkg::CMD_ZOOM_OUT, 0, 0);
		queue_cmd(vpz_pkg::CMD_PAN_RIGHT, 0, 0);
		queue_cmd(vpz_pkg::CMD_PAN_UP, 0, 0);
		queue_cmd(vpz_pkg::CMD_CURSOR_OUT, 1023, 0);
		queue_cmd(vpz_pkg::CMD_CURSOR_OUT, 0, 1023);
		queue_cmd(vpz_pkg::CMD_ZOOM_IN, 0, 0);
		wait_drained();

		// Random phases: free-running (with one long output hold-off while
		// the sender keeps pushing), sender idling, receiver stalling, both.
		run_phase(0, 0, PHASE_ITEMS, 1'b1);
		run_phase(83, 0, PHASE_ITEMS, 1'b0);
		run_phase(0, 83, PHASE_ITEMS, 1'b0);
		run_phase(25, 25, PHASE_ITEMS, 1'b0);

		// let any stray result show up before the verdict
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (expected_bounds.size() != 0) begin
			$error("%0d results never arrived", expected_bounds.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("tb_viewport_pan_zoom passed");
		else
			$display("tb_viewport_pan_zoom failed");
		$finish;
	end

endmodule
